// ----- design/gbi_pkg.sv -----
// shared types and constants of the grid bilinear interpolator
package gbi_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] q16_t;

  localparam cfg_idx_t CFG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t CFG_STEP_X   = 3'd2;
  localparam cfg_idx_t CFG_STEP_Y   = 3'd3;
  localparam cfg_idx_t CFG_COLS     = 3'd4;
  localparam cfg_idx_t CFG_ROWS     = 3'd5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic vld;
    logic oob;
  } blend_ctl_t;

endpackage

// ----- design/gbi_ram.sv -----
// single-port height store with registered read data
module gbi_ram (
  input  logic           clk,
  input  logic           we,
  input  gbi_pkg::addr_t addr,
  input  gbi_pkg::q16_t  wdata,
  output gbi_pkg::q16_t  rdata
);

  gbi_pkg::q16_t mem [0:(1 << gbi_pkg::ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/gbi_div.sv -----
// pipelined restoring divider giving cell index and fraction of one axis
module gbi_div #(
  parameter int IW        = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [32:0]         n,
  input  logic signed [32:0]         d,
  output logic [IW+FRAC_BITS-1:0]    q,
  output logic                       bad
);

  localparam int QW = IW + FRAC_BITS;

  logic [32:0] nm_a_r;
  logic [31:0] dm_a_r;
  logic        bad_a_r;

  logic [31:0]   rem_r [0:QW];
  logic [QW-1:0] w_r   [0:QW];
  logic [31:0]   dm_r  [0:QW];
  logic          bad_r [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      nm_a_r  <= n[32] ? 33'(-n) : 33'(n);
      dm_a_r  <= d[32] ? 32'(-d) : 32'(d);
      bad_a_r <= (d == '0) || ((n != '0) && (n[32] != d[32]));
      rem_r[0] <= 32'(nm_a_r >> IW);
      w_r[0]   <= {nm_a_r[IW-1:0], {FRAC_BITS{1'b0}}};
      dm_r[0]  <= dm_a_r;
      bad_r[0] <= bad_a_r || ((nm_a_r >> IW) >= {1'b0, dm_a_r});
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [32:0] tr;
    logic [32:0] sub;
    logic        ge;
    assign tr  = {rem_r[k-1], w_r[k-1][QW-1]};
    assign sub = tr - {1'b0, dm_r[k-1]};
    assign ge  = tr >= {1'b0, dm_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? sub[31:0] : tr[31:0];
        w_r[k]   <= {w_r[k-1][QW-2:0], ge};
        dm_r[k]  <= dm_r[k-1];
        bad_r[k] <= bad_r[k-1];
      end
    end
  end

  assign q   = w_r[QW];
  assign bad = bad_r[QW];

endmodule

// ----- design/gbi_blend.sv -----
// four-stage bilinear blend of the corner heights
module gbi_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gbi_pkg::blend_ctl_t    in_ctl,
  input  logic [FRAC_BITS-1:0]   in_fx,
  input  logic [FRAC_BITS-1:0]   in_fy,
  input  gbi_pkg::q16_t          h0,
  input  gbi_pkg::q16_t          h1,
  input  gbi_pkg::q16_t          h2,
  input  gbi_pkg::q16_t          h3,
  output gbi_pkg::blend_ctl_t    out_ctl,
  output gbi_pkg::q16_t          out_height
);

  localparam int PW = FRAC_BITS + 34;

  gbi_pkg::blend_ctl_t c1_r, c2_r, c3_r, c4_r;
  logic [FRAC_BITS-1:0] fy1_r, fy2_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, q0_r, q1_r;
  gbi_pkg::q16_t t1_r, t2_r, h_r;

  logic [FRAC_BITS:0]   wx0, wy0;
  logic signed [PW:0]   sa, sb, sc;

  assign wx0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, in_fx};
  assign wy0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fy2_r};
  assign sa  = {p0_r[PW-1], p0_r} + {p1_r[PW-1], p1_r};
  assign sb  = {p2_r[PW-1], p2_r} + {p3_r[PW-1], p3_r};
  assign sc  = {q0_r[PW-1], q0_r} + {q1_r[PW-1], q1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    p0_r  <= $signed({1'b0, wx0}) * h0;
    p1_r  <= $signed({2'b00, in_fx}) * h1;
    p2_r  <= $signed({1'b0, wx0}) * h2;
    p3_r  <= $signed({2'b00, in_fx}) * h3;
    fy1_r <= in_fy;
    t1_r  <= gbi_pkg::DATA_W'(sa >>> FRAC_BITS);
    t2_r  <= gbi_pkg::DATA_W'(sb >>> FRAC_BITS);
    fy2_r <= fy1_r;
    q0_r  <= $signed({1'b0, wy0}) * t1_r;
    q1_r  <= $signed({2'b00, fy2_r}) * t2_r;
    h_r   <= c3_r.oob ? '0 : gbi_pkg::DATA_W'(sc >>> FRAC_BITS);
  end

  assign out_ctl    = c4_r;
  assign out_height = h_r;

endmodule

// ----- design/grid_bilinear_interpolator_core.sv -----
// top level: bilinear interpolation over a regular grid of heights
// a query makes four corner reads of the single-port store and blocks new entries until done
// a load writes one entry through the store port and gives no result
// rst_n synchronous active low clears control and resets config; data and store undefined
// results are strobed on out_valid for one cycle; the receiver cannot stall
module grid_bilinear_interpolator_core #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic [15:0]              in_entry_index,
  input  logic signed [31:0]       in_entry_height,
  input  logic signed [31:0]       in_query_x,
  input  logic signed [31:0]       in_query_y,
  output logic                     out_valid,
  output logic signed [31:0]       out_height_out,
  output logic                     out_out_of_bounds,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  gbi_pkg::cfg_idx_t        cfg_index,
  input  logic [31:0]              cfg_data
);

  localparam int IW_X  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IW_Y  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IW    = (IW_X > IW_Y) ? IW_X : IW_Y;
  localparam int QW    = IW + FRAC_BITS;
  localparam int DL    = QW + 2;
  localparam int LIM_C = (MAX_COLS < 511) ? MAX_COLS : 511;
  localparam int LIM_R = (MAX_ROWS < 511) ? MAX_ROWS : 511;

  // configuration registers
  gbi_pkg::q16_t origin_x_r, origin_y_r, step_y_r;
  logic [30:0]   step_x_r;
  logic [8:0]    cols_r, rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_x_r   <= 31'd65536;
      step_y_r   <= 32'sd65536;
      cols_r     <= 9'd2;
      rows_r     <= 9'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gbi_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        gbi_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        gbi_pkg::CFG_STEP_X:   step_x_r   <= cfg_data[30:0];
        gbi_pkg::CFG_STEP_Y:   step_y_r   <= cfg_data;
        gbi_pkg::CFG_COLS:     cols_r     <= cfg_data[8:0];
        gbi_pkg::CFG_ROWS:     rows_r     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0] ec, er;
  assign ec = (cols_r > 9'(LIM_C)) ? 9'(LIM_C) : cols_r;
  assign er = (rows_r > 9'(LIM_R)) ? 9'(LIM_R) : rows_r;

  // pipeline control
  logic adv, can_take, take, take_q;
  logic seq_act_r;
  logic p_v_r;

  assign can_take = !seq_act_r;
  assign take     = p_v_r && can_take;
  assign adv      = !p_v_r || can_take;
  assign busy     = !adv;

  // entry stage: offsets from origin
  logic                  s0_v_r, s0_func_r;
  gbi_pkg::addr_t        s0_idx_r;
  gbi_pkg::q16_t         s0_hgt_r;
  logic signed [32:0]    s0_ox_r, s0_oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_func_r <= in_func;
      s0_idx_r  <= in_entry_index;
      s0_hgt_r  <= in_entry_height;
      s0_ox_r   <= {in_query_x[31], in_query_x} - {origin_x_r[31], origin_x_r};
      s0_oy_r   <= {in_query_y[31], in_query_y} - {origin_y_r[31], origin_y_r};
    end
  end

  // dividers
  logic [QW-1:0] qx_q, qy_q;
  logic          bad_x, bad_y;

  gbi_div #(.IW(IW), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk),
    .en  (adv),
    .n   (s0_ox_r),
    .d   ({2'b00, step_x_r}),
    .q   (qx_q),
    .bad (bad_x)
  );

  gbi_div #(.IW(IW), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk),
    .en  (adv),
    .n   (s0_oy_r),
    .d   ({step_y_r[31], step_y_r}),
    .q   (qy_q),
    .bad (bad_y)
  );

  // transaction data alongside the dividers
  logic           sd_v_r    [0:DL-1];
  logic           sd_func_r [0:DL-1];
  gbi_pkg::addr_t sd_idx_r  [0:DL-1];
  gbi_pkg::q16_t  sd_hgt_r  [0:DL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DL; k++) begin
        sd_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      sd_v_r[0] <= s0_v_r;
      for (int k = 1; k < DL; k++) begin
        sd_v_r[k] <= sd_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_func_r[0] <= s0_func_r;
      sd_idx_r[0]  <= s0_idx_r;
      sd_hgt_r[0]  <= s0_hgt_r;
      for (int k = 1; k < DL; k++) begin
        sd_func_r[k] <= sd_func_r[k-1];
        sd_idx_r[k]  <= sd_idx_r[k-1];
        sd_hgt_r[k]  <= sd_hgt_r[k-1];
      end
    end
  end

  // cell check and base address
  logic [IW-1:0]        ix, iy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 oob;
  logic [31:0]          base_full;

  assign ix = qx_q[QW-1:FRAC_BITS];
  assign iy = qy_q[QW-1:FRAC_BITS];
  assign fx = qx_q[FRAC_BITS-1:0];
  assign fy = qy_q[FRAC_BITS-1:0];
  assign oob = bad_x || bad_y || (ec < 9'd2) || (er < 9'd2) ||
               ((32'(ix) + 32'd1) >= 32'(ec)) || ((32'(iy) + 32'd1) >= 32'(er));
  assign base_full = 32'(ix) + 32'(ec) * 32'(iy);

  logic                 p_func_r, p_oob_r;
  gbi_pkg::addr_t       p_idx_r, p_base_r;
  gbi_pkg::q16_t        p_hgt_r;
  logic [FRAC_BITS-1:0] p_fx_r, p_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= sd_v_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_func_r <= sd_func_r[DL-1];
      p_idx_r  <= sd_idx_r[DL-1];
      p_hgt_r  <= sd_hgt_r[DL-1];
      p_base_r <= base_full[15:0];
      p_fx_r   <= fx;
      p_fy_r   <= fy;
      p_oob_r  <= oob;
    end
  end

  // corner read sequencer
  logic [1:0]           seq_cnt_r;
  gbi_pkg::addr_t       base_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic                 oob_r;
  logic                 rd_v_r;
  logic [1:0]           rd_k_r;
  gbi_pkg::q16_t        h0_r, h1_r, h2_r;

  logic           ram_we;
  gbi_pkg::addr_t ram_addr, seq_addr;
  gbi_pkg::q16_t  ram_rdata;

  assign take_q   = take && (p_func_r == gbi_pkg::FUNC_QUERY);
  assign seq_addr = base_r + (seq_cnt_r[1] ? 16'(ec) : 16'd0) + {15'd0, seq_cnt_r[0]};

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = seq_addr;
    if (take) begin
      if (p_func_r == gbi_pkg::FUNC_LOAD) begin
        ram_we   = 1'b1;
        ram_addr = p_idx_r;
      end else begin
        ram_addr = p_base_r;
      end
    end
  end

  gbi_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (p_hgt_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_act_r <= 1'b0;
      seq_cnt_r <= 2'd0;
      rd_v_r    <= 1'b0;
      rd_k_r    <= 2'd0;
    end else begin
      if (take_q) begin
        seq_act_r <= 1'b1;
        seq_cnt_r <= 2'd1;
      end else if (seq_act_r) begin
        seq_cnt_r <= seq_cnt_r + 2'd1;
        if (seq_cnt_r == 2'd3) begin
          seq_act_r <= 1'b0;
        end
      end
      rd_v_r <= take_q || seq_act_r;
      rd_k_r <= take_q ? 2'd0 : seq_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_q) begin
      base_r <= p_base_r;
      fx_r   <= p_fx_r;
      fy_r   <= p_fy_r;
      oob_r  <= p_oob_r;
    end
    if (rd_v_r) begin
      case (rd_k_r)
        2'd0: h0_r <= ram_rdata;
        2'd1: h1_r <= ram_rdata;
        2'd2: h2_r <= ram_rdata;
        default: ;
      endcase
    end
  end

  // blend
  gbi_pkg::blend_ctl_t launch_ctl, out_ctl;

  assign launch_ctl.vld = rd_v_r && (rd_k_r == 2'd3);
  assign launch_ctl.oob = oob_r;

  gbi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (launch_ctl),
    .in_fx      (fx_r),
    .in_fy      (fy_r),
    .h0         (h0_r),
    .h1         (h1_r),
    .h2         (h2_r),
    .h3         (ram_rdata),
    .out_ctl    (out_ctl),
    .out_height (out_height_out)
  );

  assign out_valid         = out_ctl.vld;
  assign out_out_of_bounds = out_ctl.oob;

`ifndef SYNTHESIS
  a_store_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !seq_act_r)
    else $error("store written during corner reads");

  a_take_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
    take_q |=> (seq_act_r && (seq_cnt_r == 2'd1)))
    else $error("query taken without starting corner reads");

  a_launch_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
    launch_ctl.vld |-> !seq_act_r)
    else $error("blend launched while corner reads still running");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_bounds) |-> (out_height_out == '0))
    else $error("out of bounds result with nonzero height");
`endif

endmodule
